### sv/rna_pkg.sv
// ----------------------------------------------------------------------------
// rna_pkg
// shared widths, opcodes and the command/status bundles between the fraction
// alu controller and its datapath
// ----------------------------------------------------------------------------
package rna_pkg;

    // fixed field widths of the stream words
    localparam int FIELD_W = 16;
    localparam int RES_W   = 33;
    localparam int OP_W    = 3;

    // request opcodes (codes six and seven are unused and flagged invalid)
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP = 3'd4;
    localparam logic [OP_W-1:0] OP_RED = 3'd5;

    // operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        MS_AN_BD = 2'd0,
        MS_AD_BN = 2'd1,
        MS_AN_BN = 2'd2,
        MS_AD_BD = 2'd3
    } t_mul_sel;

    // product register written by the multiplier
    typedef enum logic [1:0] {
        PD_0 = 2'd0,
        PD_1 = 2'd1,
        PD_2 = 2'd2
    } t_prod_dst;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      mul_en;
        t_mul_sel  mul_sel;
        t_prod_dst mul_dst;
        logic      gcd_init;
        logic      gcd_step;
        logic      div_init;
        logic      div_step;
        logic      out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            a_zero;
        logic            gcd_done;
        logic            div_done;
    } t_dp_sts;

endpackage

### sv/rational_number_alu_top.sv
// ----------------------------------------------------------------------------
// rational_number_alu_top
// fraction alu: add, subtract, multiply, divide, compare and reduce of signed
// fractions over stream words
// ----------------------------------------------------------------------------
// One request word is taken at a time and gives one result word. After the
// load, multiply, divide and compare use the shared multiplier in states
// MUL0 and MUL1, add and subtract also in MUL2 (one shared multiplier forms
// the cross products one per cycle); unused opcodes and reduce with a zero
// part go straight to the finish state, and other reduces run the binary gcd
// steps and then the two-lane divider over WIDTH bits. A new request is
// taken the cycle after the result moves into the output register, so a
// waiting result does not block the next request's work. Operands are the
// low WIDTH bits of each field, sign extended; results wrap to 33 bits.
module rational_number_alu_top #(
    parameter int WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // a_num[15:0], a_den[31:16], b_num[47:32], b_den[63:48]
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata    // res_num[32:0], res_den[65:33], less[66], equal[67],
                                     // greater[68], invalid[69], zero[71:70]
);

    rna_pkg::t_dp_cmd w_cmd;
    rna_pkg::t_dp_sts w_sts;

    logic signed [rna_pkg::RES_W-1:0] w_res_num, w_res_den;
    logic                             w_less, w_equal, w_greater, w_invalid;

    logic                             r_valid;
    logic [rna_pkg::RES_W-1:0]        r_res_num, r_res_den;
    logic                             r_less, r_equal, r_greater, r_invalid;
    logic                             w_out_free;

    assign w_out_free = !r_valid || i_m_tready;

    rna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rna_dp #(
        .W (WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_req_type (i_s_tuser),
        .i_a_num    (i_s_tdata[15:0]),
        .i_a_den    (i_s_tdata[31:16]),
        .i_b_num    (i_s_tdata[47:32]),
        .i_b_den    (i_s_tdata[63:48]),
        .o_sts      (w_sts),
        .o_res_num  (w_res_num),
        .o_res_den  (w_res_den),
        .o_less     (w_less),
        .o_equal    (w_equal),
        .o_greater  (w_greater),
        .o_invalid  (w_invalid)
    );

    // output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_res_num <= w_res_num;
            r_res_den <= w_res_den;
            r_less    <= w_less;
            r_equal   <= w_equal;
            r_greater <= w_greater;
            r_invalid <= w_invalid;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_invalid, r_greater, r_equal, r_less, r_res_den, r_res_num};

endmodule

### sv/rna_ctrl.sv
// ----------------------------------------------------------------------------
// rna_ctrl
// sequencer of the fraction alu: loads a request, steps the shared multiplier,
// the binary gcd and the two-lane divider, then hands the result to the output
// register
// ----------------------------------------------------------------------------
module rna_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_out_free,
    input  rna_pkg::t_dp_sts  i_sts,
    output rna_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_MUL0 = 8'b0000_0100,
        S_MUL1 = 8'b0000_1000,
        S_MUL2 = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                unique case (i_sts.op) inside
                    rna_pkg::OP_ADD, rna_pkg::OP_SUB, rna_pkg::OP_MUL,
                    rna_pkg::OP_DIV, rna_pkg::OP_CMP: begin
                        n_state = S_MUL0;
                    end
                    rna_pkg::OP_RED: begin
                        if (i_sts.a_zero) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.gcd_init = 1'b1;
                            n_state        = S_GCD;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_dst = rna_pkg::PD_0;
                o_cmd.mul_sel = (i_sts.op == rna_pkg::OP_MUL) ? rna_pkg::MS_AN_BN
                                                              : rna_pkg::MS_AN_BD;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                if (i_sts.op == rna_pkg::OP_MUL) begin
                    o_cmd.mul_sel = rna_pkg::MS_AD_BD;
                    o_cmd.mul_dst = rna_pkg::PD_2;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.mul_sel = rna_pkg::MS_AD_BN;
                    o_cmd.mul_dst = rna_pkg::PD_1;
                    if (i_sts.op == rna_pkg::OP_ADD || i_sts.op == rna_pkg::OP_SUB) begin
                        n_state = S_MUL2;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rna_pkg::MS_AD_BD;
                o_cmd.mul_dst = rna_pkg::PD_2;
                n_state       = S_FIN;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/rna_dp.sv
// ----------------------------------------------------------------------------
// rna_dp
// datapath of the fraction alu: operand registers, one shared multiplier with
// three product registers, a binary gcd unit and a two-lane restoring divider
// ----------------------------------------------------------------------------
module rna_dp #(
    parameter int W = 16
) (
    input  logic                                   i_clk,
    input  rna_pkg::t_dp_cmd                       i_cmd,
    input  logic [rna_pkg::OP_W-1:0]               i_req_type,
    input  logic [rna_pkg::FIELD_W-1:0]            i_a_num,
    input  logic [rna_pkg::FIELD_W-1:0]            i_a_den,
    input  logic [rna_pkg::FIELD_W-1:0]            i_b_num,
    input  logic [rna_pkg::FIELD_W-1:0]            i_b_den,
    output rna_pkg::t_dp_sts                       o_sts,
    output logic signed [rna_pkg::RES_W-1:0]       o_res_num,
    output logic signed [rna_pkg::RES_W-1:0]       o_res_den,
    output logic                                   o_less,
    output logic                                   o_equal,
    output logic                                   o_greater,
    output logic                                   o_invalid
);

    localparam int MW = (W > rna_pkg::FIELD_W) ? W : rna_pkg::FIELD_W;
    localparam int PW = 2 * W + 2;
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W + 1);

    // low W bits of a field, sign extended by one bit for negation headroom
    function automatic logic signed [W:0] f_ext(input logic [rna_pkg::FIELD_W-1:0] f);
        logic [MW-1:0] z;
        z = MW'(f);
        return {z[W-1], z[W-1:0]};
    endfunction

    logic [rna_pkg::OP_W-1:0] r_op;
    logic signed [W:0]        r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0]     r_p0, r_p1, r_p2;
    logic [W-1:0]             r_gx, r_gy;
    logic [KW-1:0]            r_gk;
    logic [W-1:0]             r_g;
    logic [W-1:0]             r_dvn, r_dvd, r_rmn, r_rmd;
    logic [CW-1:0]            r_cnt;

    // operand capture, compare moves denominator signs onto numerators
    logic signed [W:0] ld_an, ld_ad, ld_bn, ld_bd;
    logic              ld_cmp;

    always_comb begin
        ld_cmp = (i_req_type == rna_pkg::OP_CMP);
        ld_an  = f_ext(i_a_num);
        ld_ad  = f_ext(i_a_den);
        ld_bn  = f_ext(i_b_num);
        ld_bd  = f_ext(i_b_den);
        if (ld_cmp && ld_ad[W]) begin
            ld_an = -ld_an;
            ld_ad = -ld_ad;
        end
        if (ld_cmp && ld_bd[W]) begin
            ld_bn = -ld_bn;
            ld_bd = -ld_bd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_req_type;
            r_an <= ld_an;
            r_ad <= ld_ad;
            r_bn <= ld_bn;
            r_bd <= ld_bd;
        end
    end

    // shared multiplier
    logic signed [W:0]    mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        case (i_cmd.mul_sel)
            rna_pkg::MS_AN_BD: begin mul_a = r_an; mul_b = r_bd; end
            rna_pkg::MS_AD_BN: begin mul_a = r_ad; mul_b = r_bn; end
            rna_pkg::MS_AN_BN: begin mul_a = r_an; mul_b = r_bn; end
            default:           begin mul_a = r_ad; mul_b = r_bd; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_dst)
                rna_pkg::PD_0: r_p0 <= mul_p;
                rna_pkg::PD_1: r_p1 <= mul_p;
                default:       r_p2 <= mul_p;
            endcase
        end
    end

    // magnitudes of a for reduce
    logic signed [W:0] neg_an, neg_ad;
    logic [W-1:0]      mag_an, mag_ad;

    assign neg_an = -r_an;
    assign neg_ad = -r_ad;
    assign mag_an = r_an[W] ? neg_an[W-1:0] : r_an[W-1:0];
    assign mag_ad = r_ad[W] ? neg_ad[W-1:0] : r_ad[W-1:0];

    // binary gcd, one halving or subtraction per step
    logic gcd_done;
    assign gcd_done = (r_gx == r_gy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_gx <= mag_an;
            r_gy <= mag_ad;
            r_gk <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx > r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
    end

    // two restoring divider lanes sharing the gcd as divisor
    logic [W:0]   trial_n, trial_d, diff_n, diff_d;
    logic         ge_n, ge_d;
    logic         div_done;

    assign trial_n  = {r_rmn, r_dvn[W-1]};
    assign trial_d  = {r_rmd, r_dvd[W-1]};
    assign ge_n     = (trial_n >= {1'b0, r_g});
    assign ge_d     = (trial_d >= {1'b0, r_g});
    assign diff_n   = trial_n - {1'b0, r_g};
    assign diff_d   = trial_d - {1'b0, r_g};
    assign div_done = (r_cnt == CW'(W));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_g   <= r_gx << r_gk;
            r_dvn <= mag_an;
            r_dvd <= mag_ad;
            r_rmn <= '0;
            r_rmd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rmn <= ge_n ? diff_n[W-1:0] : trial_n[W-1:0];
            r_rmd <= ge_d ? diff_d[W-1:0] : trial_d[W-1:0];
            r_dvn <= {r_dvn[W-2:0], ge_n};
            r_dvd <= {r_dvd[W-2:0], ge_d};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // status to the controller
    assign o_sts.op       = r_op;
    assign o_sts.a_zero   = (r_an == '0) || (r_ad == '0);
    assign o_sts.gcd_done = gcd_done;
    assign o_sts.div_done = div_done;

    // result selection
    logic signed [PW-1:0] p_sum, p_diff;
    logic signed [W:0]    q_num, q_den, red_num, red_den;

    assign p_sum   = r_p0 + r_p1;
    assign p_diff  = r_p0 - r_p1;
    assign q_num   = {1'b0, r_dvn};
    assign q_den   = {1'b0, r_dvd};
    assign red_num = r_an[W] ? -q_num : q_num;
    assign red_den = r_ad[W] ? -q_den : q_den;

    always_comb begin
        o_res_num = '0;
        o_res_den = '0;
        o_less    = 1'b0;
        o_equal   = 1'b0;
        o_greater = 1'b0;
        o_invalid = 1'b0;
        case (r_op)
            rna_pkg::OP_ADD: begin
                o_res_num = rna_pkg::RES_W'(p_sum);
                o_res_den = rna_pkg::RES_W'(r_p2);
            end
            rna_pkg::OP_SUB: begin
                o_res_num = rna_pkg::RES_W'(p_diff);
                o_res_den = rna_pkg::RES_W'(r_p2);
            end
            rna_pkg::OP_MUL: begin
                o_res_num = rna_pkg::RES_W'(r_p0);
                o_res_den = rna_pkg::RES_W'(r_p2);
            end
            rna_pkg::OP_DIV: begin
                o_res_num = rna_pkg::RES_W'(r_p0);
                o_res_den = rna_pkg::RES_W'(r_p1);
                o_invalid = (r_bn == '0);
            end
            rna_pkg::OP_CMP: begin
                if (r_ad == '0 || r_bd == '0) begin
                    o_invalid = 1'b1;
                end else begin
                    o_less    = (r_p0 < r_p1);
                    o_equal   = (r_p0 == r_p1);
                    o_greater = (r_p0 > r_p1);
                end
            end
            rna_pkg::OP_RED: begin
                if (o_sts.a_zero) begin
                    o_res_num = rna_pkg::RES_W'(r_an);
                    o_res_den = rna_pkg::RES_W'(r_ad);
                end else begin
                    o_res_num = rna_pkg::RES_W'(red_num);
                    o_res_den = rna_pkg::RES_W'(red_den);
                end
            end
            default: begin
                o_invalid = 1'b1;
            end
        endcase
    end

endmodule
